[hw/rtl/crcfr_pkg.sv]
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared constants and types of the CRC-checked frame receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

  localparam int MAX_FRAME = 64;
  localparam int ADDR_W    = $clog2(MAX_FRAME);

  // Header is source id, destination id and length; the trailer is two CRC bytes.
  localparam int HDR_BYTES = 3;
  localparam int LEN_CAP   = MAX_FRAME - 5;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] SOURCE_ID_RESET    = 8'h55;
  localparam logic [7:0] DEST_ID_RESET      = 8'hAA;
  localparam logic [5:0] LENGTH_LIMIT_RESET = 6'd59;

  // Configuration register indexes.
  localparam logic [1:0] REG_SOURCE_ID    = 2'd0;
  localparam logic [1:0] REG_DEST_ID      = 2'd1;
  localparam logic [1:0] REG_LENGTH_LIMIT = 2'd2;

  typedef enum logic [2:0] {
    PH_SRC    = 3'd0,
    PH_DST    = 3'd1,
    PH_LEN    = 3'd2,
    PH_DATA   = 3'd3,
    PH_CRC_LO = 3'd4,
    PH_CRC_HI = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_SHOW = 2'd2
  } seq_t;

  // Command to the bit-serial CRC unit.
  typedef struct packed {
    logic       start;
    logic       restart;  // seed with CRC_INIT instead of the running value
    logic [7:0] data;
  } crc_ctrl_t;

endpackage

[hw/rtl/crcfr_crc_unit.sv]
// ----------------------------------------------------------------------------
// crcfr_crc_unit
// Bit-serial CRC-16/MODBUS engine: one shift step per cycle, eight per byte.
// ----------------------------------------------------------------------------
module crcfr_crc_unit (
  input  logic                clk,
  input  logic                rst,
  input  crcfr_pkg::crc_ctrl_t ctrl,
  output logic                busy,
  output logic [15:0]         crc
);

  logic [2:0]  count;
  logic [15:0] seed;

  assign seed = ctrl.restart ? crcfr_pkg::CRC_INIT : crc;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc   <= crcfr_pkg::CRC_INIT;
      busy  <= 1'b0;
      count <= 3'd0;
    end else if (ctrl.start) begin
      crc   <= seed ^ {8'h00, ctrl.data};
      busy  <= 1'b1;
      count <= 3'd0;
    end else if (busy) begin
      if (crc[0]) begin
        crc <= (crc >> 1) ^ crcfr_pkg::CRC_POLY;
      end else begin
        crc <= crc >> 1;
      end
      count <= count + 3'd1;
      if (count == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/crcfr_frame_store.sv]
// ----------------------------------------------------------------------------
// crcfr_frame_store
// Frame byte memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module crcfr_frame_store (
  input  logic                         clk,
  input  logic                         we,
  input  logic [crcfr_pkg::ADDR_W-1:0] waddr,
  input  logic [7:0]                   wdata,
  input  logic                         re,
  input  logic [crcfr_pkg::ADDR_W-1:0] raddr,
  output logic [7:0]                   rdata
);

  logic [7:0] mem [crcfr_pkg::MAX_FRAME];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/crc_checked_frame_receiver_top.sv]
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver_top
// Serial frame receiver with CRC-16/MODBUS check and frame replay.
// ----------------------------------------------------------------------------
// Bytes are taken one item at a time and parsed as source id, destination id,
// length, payload and a two-byte CRC (low byte first). Header and payload
// bytes pass through a bit-serial CRC unit, so such an item holds in_stall
// high while the unit shifts it in; id mismatches, CRC bytes and bad lengths
// cause no such stall. A matching second CRC byte replays the stored frame
// (length + 5 bytes) from memory: each byte is read in ST_READ and shown in
// ST_SHOW until out_stall is low, frame_end marking the last; input is stalled
// throughout. A CRC mismatch drops the frame without output. Configuration
// writes are always ready and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module crc_checked_frame_receiver_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       frame_end,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int AW = crcfr_pkg::ADDR_W;

  logic [7:0] source_id;
  logic [7:0] dest_id;
  logic [5:0] length_limit;

  crcfr_pkg::phase_t parse_phase, parse_phase_next;
  crcfr_pkg::seq_t   seq, seq_next;

  logic [AW-1:0] payload_length, payload_length_next;
  logic [AW-1:0] write_position, write_position_next;
  logic [AW-1:0] emit_idx, emit_idx_next;
  logic [AW-1:0] last_idx, last_idx_next;
  logic [7:0]    crc_lo, crc_lo_next;

  crcfr_pkg::crc_ctrl_t crc_ctrl;
  logic        crc_busy;
  logic [15:0] crc_value;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_re;
  logic [7:0]    mem_rdata;

  logic          accept;
  logic [AW-1:0] data_end;

  assign cfg_ready = 1'b1;
  assign in_stall  = (seq != crcfr_pkg::ST_IDLE) || crc_busy;
  assign accept    = in_valid && !in_stall;
  assign data_end  = payload_length + AW'(crcfr_pkg::HDR_BYTES);

  assign out_valid = (seq == crcfr_pkg::ST_SHOW);
  assign out_byte  = mem_rdata;
  assign frame_end = (emit_idx == last_idx);
  assign mem_re    = (seq == crcfr_pkg::ST_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      source_id    <= crcfr_pkg::SOURCE_ID_RESET;
      dest_id      <= crcfr_pkg::DEST_ID_RESET;
      length_limit <= crcfr_pkg::LENGTH_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        crcfr_pkg::REG_SOURCE_ID:    source_id    <= cfg_data;
        crcfr_pkg::REG_DEST_ID:      dest_id      <= cfg_data;
        crcfr_pkg::REG_LENGTH_LIMIT: length_limit <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= crcfr_pkg::PH_SRC;
      seq            <= crcfr_pkg::ST_IDLE;
      payload_length <= '0;
      write_position <= '0;
      emit_idx       <= '0;
      last_idx       <= '0;
    end else begin
      parse_phase    <= parse_phase_next;
      seq            <= seq_next;
      payload_length <= payload_length_next;
      write_position <= write_position_next;
      emit_idx       <= emit_idx_next;
      last_idx       <= last_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    crc_lo <= crc_lo_next;
  end

  always_comb begin
    parse_phase_next    = parse_phase;
    seq_next            = seq;
    payload_length_next = payload_length;
    write_position_next = write_position;
    emit_idx_next       = emit_idx;
    last_idx_next       = last_idx;
    crc_lo_next         = crc_lo;
    crc_ctrl.start      = 1'b0;
    crc_ctrl.restart    = 1'b0;
    crc_ctrl.data       = in_byte;
    mem_we              = 1'b0;
    mem_waddr           = '0;

    case (seq)
      crcfr_pkg::ST_IDLE: begin
        if (accept) begin
          case (parse_phase)
            crcfr_pkg::PH_SRC: begin
              if (in_byte == source_id) begin
                mem_we           = 1'b1;
                mem_waddr        = AW'(0);
                crc_ctrl.start   = 1'b1;
                crc_ctrl.restart = 1'b1;
                parse_phase_next = crcfr_pkg::PH_DST;
              end
            end
            crcfr_pkg::PH_DST: begin
              if (in_byte == dest_id) begin
                mem_we           = 1'b1;
                mem_waddr        = AW'(1);
                crc_ctrl.start   = 1'b1;
                parse_phase_next = crcfr_pkg::PH_LEN;
              end else begin
                parse_phase_next = crcfr_pkg::PH_SRC;
              end
            end
            crcfr_pkg::PH_LEN: begin
              if (in_byte != 8'd0 && in_byte < {2'b00, length_limit} &&
                  in_byte < 8'(crcfr_pkg::LEN_CAP)) begin
                mem_we              = 1'b1;
                mem_waddr           = AW'(2);
                crc_ctrl.start      = 1'b1;
                payload_length_next = in_byte[AW-1:0];
                write_position_next = AW'(crcfr_pkg::HDR_BYTES);
                parse_phase_next    = crcfr_pkg::PH_DATA;
              end else begin
                parse_phase_next = crcfr_pkg::PH_SRC;
              end
            end
            crcfr_pkg::PH_DATA: begin
              if (write_position < data_end) begin
                mem_we              = 1'b1;
                mem_waddr           = write_position;
                crc_ctrl.start      = 1'b1;
                write_position_next = write_position + AW'(1);
                if (write_position_next == data_end) begin
                  parse_phase_next = crcfr_pkg::PH_CRC_LO;
                end
              end else begin
                parse_phase_next = crcfr_pkg::PH_SRC;
              end
            end
            crcfr_pkg::PH_CRC_LO: begin
              mem_we           = 1'b1;
              mem_waddr        = data_end;
              crc_lo_next      = in_byte;
              parse_phase_next = crcfr_pkg::PH_CRC_HI;
            end
            crcfr_pkg::PH_CRC_HI: begin
              mem_we           = 1'b1;
              mem_waddr        = data_end + AW'(1);
              parse_phase_next = crcfr_pkg::PH_SRC;
              if ({in_byte, crc_lo} == crc_value) begin
                emit_idx_next = '0;
                last_idx_next = data_end + AW'(1);
                seq_next      = crcfr_pkg::ST_READ;
              end
            end
            default: begin
              parse_phase_next = crcfr_pkg::PH_SRC;
            end
          endcase
        end
      end
      crcfr_pkg::ST_READ: begin
        seq_next = crcfr_pkg::ST_SHOW;
      end
      crcfr_pkg::ST_SHOW: begin
        if (!out_stall) begin
          if (emit_idx == last_idx) begin
            seq_next = crcfr_pkg::ST_IDLE;
          end else begin
            emit_idx_next = emit_idx + AW'(1);
            seq_next      = crcfr_pkg::ST_READ;
          end
        end
      end
      default: begin
        seq_next = crcfr_pkg::ST_IDLE;
      end
    endcase
  end

  crcfr_crc_unit u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctrl (crc_ctrl),
    .busy (crc_busy),
    .crc  (crc_value)
  );

  crcfr_frame_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_byte),
    .re    (mem_re),
    .raddr (emit_idx),
    .rdata (mem_rdata)
  );

endmodule
